// ===== hdl/etbd_pkg.sv =====
// ----------------------------------------------------------------------------
// etbd_pkg: shared types and constants of the edge-timed barcode decoder
// Status codes, configuration indexes, result record and serial widths.
// ----------------------------------------------------------------------------
package etbd_pkg;

  // timestamp and duration width
  localparam int unsigned TS_W = 32;
  // bit-serial step counter width (one timestamp bit per cycle)
  localparam int unsigned SER_CNT_W = $clog2(TS_W);
  // configuration register width and index width
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  // decoded code width on the result channel
  localparam int unsigned CODE_W = 8;
  // velocity scale applied to bit_length
  localparam logic [TS_W-1:0] VEL_SCALE = 32'd1000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_LENGTH      = 1'b0,
    CFG_READING_TIMEOUT = 1'b1
  } cfg_idx_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_PROGRESS = 3'd1,
    ST_SUCCESS  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_POLL,
    S_DIV,
    S_RESP
  } state_e;

  // one result record
  typedef struct packed {
    status_e             status;
    logic [CODE_W-1:0]   code;
    logic [TS_W-1:0]     vel;
  } resp_t;

endpackage

// ===== hdl/etbd_div.sv =====
// ----------------------------------------------------------------------------
// etbd_div: bit-serial restoring divider
// Produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etbd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [etbd_pkg::TS_W-1:0] dividend_i,
  input  logic [etbd_pkg::TS_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [etbd_pkg::TS_W-1:0] quotient_o
);
  import etbd_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [SER_CNT_W-1:0] cnt_q, cnt_d;
  logic [TS_W-1:0]      rem_q, rem_d;
  logic [TS_W-1:0]      quo_q, quo_d;
  logic [TS_W-1:0]      dvs_q, dvs_d;
  logic [TS_W:0]        trial;

  // shift in the next dividend bit and try to subtract the divisor
  assign trial = {rem_q, quo_q[TS_W-1]} - {1'b0, dvs_q};

  // one restoring step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[TS_W]) begin
        rem_d = {rem_q[TS_W-2:0], quo_q[TS_W-1]};
        quo_d = {quo_q[TS_W-2:0], 1'b0};
      end else begin
        rem_d = trial[TS_W-1:0];
        quo_d = {quo_q[TS_W-2:0], 1'b1};
      end
      cnt_d = cnt_q + SER_CNT_W'(1);
      if (cnt_q == SER_CNT_W'(TS_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/edge_timed_barcode_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// edge_timed_barcode_decoder_unit: edge-timed barcode decoder
// Times sensor edges bit-serially, decodes the bar code and reports status.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries edges (tuser 0) and polls (tuser 1); tdata holds the pin
//   level and the 32-bit microsecond timestamp. An edge produces no result,
//   a poll produces exactly one result on m_axis (status in tuser, code and
//   velocity in tdata).
//   An edge that stores a duration occupies the unit while the timestamp
//   difference, the white/black compare and the bit period are worked out
//   one bit per cycle; other edges need no serial pass.
//   A poll reporting mismatch, no code or success with a zero period goes
//   via the S_RESP state to the output register; a timeout check first runs
//   the serial elapsed-time compare and a success first runs the 32-step
//   serial divider for the velocity.
//   The result sits in an output register, so the next item is taken while
//   it waits; a poll finishing while that register is still full holds until
//   the receiver takes the previous result.
//   Reset clears the counters, the pending error and both configuration
//   registers; the unit is ready right after reset.
//   Configuration writes are taken in any cycle on the write port.
// ----------------------------------------------------------------------------
module edge_timed_barcode_decoder_unit #(
  parameter int unsigned CODE_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [etbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [etbd_pkg::CFG_W-1:0]    cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [39:0]                   s_axis_tdata_i,  // pin_level, timestamp, zero pad
  input  logic [0:0]                    s_axis_tuser_i,  // func
  // result items
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [39:0]                   m_axis_tdata_o,  // code_value, velocity
  output logic [2:0]                    m_axis_tuser_o   // status
);
  import etbd_pkg::*;

  localparam int unsigned FULL_EDGES = 2 * CODE_BITS + 2;
  localparam int unsigned CNT_W      = $clog2(FULL_EDGES + 1);
  localparam int unsigned IDX_W      = $clog2(CODE_BITS + 1);

  // configuration registers
  logic [CFG_W-1:0] bit_length_q, reading_timeout_q;

  // read state
  logic [CNT_W-1:0]     edge_count_q, edge_count_d;
  logic [IDX_W-1:0]     bit_index_q, bit_index_d;
  logic [TS_W-1:0]      last_q, last_d;
  logic                 err_q, err_d;
  logic [TS_W-1:0]      white_q, white_d;
  logic [TS_W-1:0]      period_q, period_d;
  logic [CODE_BITS-1:0] code_q, code_d;

  // serial datapath
  logic [TS_W-1:0]      ts_sr_q, ts_sr_d;
  logic [CFG_W-1:0]     tmo_sr_q, tmo_sr_d;
  logic [SER_CNT_W-1:0] cyc_q, cyc_d;
  logic                 brw_q, brw_d;
  logic                 cry_q, cry_d;
  logic                 gt_q, gt_d;
  logic                 rising_q, rising_d;

  // sequencer and result staging
  state_e state_q, state_d;
  resp_t  resp_q, resp_d;
  resp_t  out_q;
  logic   out_valid_q;

  // item decode
  logic             in_acc, is_poll, pin;
  logic [TS_W-1:0]  ts_in;
  logic [CNT_W-1:0] cnt_inc;
  logic             phase_ok, edge_full, period_zero;
  logic             start_edge_ser, start_poll_ser, start_div, resp_direct;

  // sequencer outputs
  logic ready, ser_en, ser_last, resp_wr;

  // serial bit signals
  logic ser_a, ser_b, ser_diff, ser_w, ser_sum, gt_nxt;

  // divider link
  logic            div_done;
  logic [TS_W-1:0] div_quo;

  // ---------------------------------------------------------------- decode
  assign pin         = s_axis_tdata_i[0];
  assign ts_in       = s_axis_tdata_i[TS_W:1];
  assign is_poll     = s_axis_tuser_i[0];
  assign in_acc      = s_axis_tvalid_i & ready;
  assign cnt_inc     = edge_count_q + CNT_W'(1);
  assign phase_ok    = (pin == cnt_inc[0]);
  assign edge_full   = (edge_count_q >= CNT_W'(FULL_EDGES));
  assign period_zero = (period_q == '0);

  assign start_edge_ser = in_acc & ~is_poll & ~edge_full & phase_ok &
                          (cnt_inc != CNT_W'(1)) & (cnt_inc != CNT_W'(FULL_EDGES));
  assign start_poll_ser = in_acc & is_poll & ~err_q & ~edge_full &
                          (edge_count_q != '0);
  assign start_div      = in_acc & is_poll & ~err_q & edge_full & ~period_zero;
  assign resp_direct    = in_acc & is_poll & ~start_poll_ser & ~start_div;

  // ---------------------------------------------------------------- serial bit
  // lsb-first subtract now - last, plus add/compare against white or timeout
  assign ser_a    = ts_sr_q[0];
  assign ser_b    = last_q[0];
  assign ser_diff = ser_a ^ ser_b ^ brw_q;
  assign ser_w    = white_q[0];
  assign ser_sum  = ser_w ^ ser_diff ^ cry_q;
  assign ser_last = ser_en & (cyc_q == SER_CNT_W'(TS_W - 1));

  always_comb begin
    gt_nxt = gt_q;
    if (state_q == S_POLL) begin
      if (ser_diff != tmo_sr_q[0]) begin
        gt_nxt = ser_diff;
      end
    end else if (ser_w != ser_diff) begin
      gt_nxt = ser_w;
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_edge_ser) begin
          state_d = S_EDGE;
        end else if (start_poll_ser) begin
          state_d = S_POLL;
        end else if (start_div) begin
          state_d = S_DIV;
        end else if (resp_direct) begin
          state_d = S_RESP;
        end
      end
      S_EDGE: begin
        if (ser_last) state_d = S_IDLE;
      end
      S_POLL: begin
        if (ser_last) state_d = S_RESP;
      end
      S_DIV: begin
        if (div_done) state_d = S_RESP;
      end
      S_RESP: begin
        if (resp_wr) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- sequencer outputs
  always_comb begin
    ready   = 1'b0;
    ser_en  = 1'b0;
    resp_wr = 1'b0;
    unique case (state_q)
      S_IDLE:         ready   = 1'b1;
      S_EDGE, S_POLL: ser_en  = 1'b1;
      S_RESP:         resp_wr = ~out_valid_q | m_axis_tready_i;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    edge_count_d = edge_count_q;
    bit_index_d  = bit_index_q;
    last_d       = last_q;
    err_d        = err_q;
    white_d      = white_q;
    period_d     = period_q;
    code_d       = code_q;
    ts_sr_d      = ts_sr_q;
    tmo_sr_d     = tmo_sr_q;
    cyc_d        = cyc_q;
    brw_d        = brw_q;
    cry_d        = cry_q;
    gt_d         = gt_q;
    rising_d     = rising_q;
    resp_d       = resp_q;

    // accepted edge
    if (in_acc && !is_poll && !edge_full) begin
      if (!phase_ok) begin
        edge_count_d = '0;
        bit_index_d  = '0;
        err_d        = 1'b1;
      end else begin
        edge_count_d = cnt_inc;
        if (cnt_inc == CNT_W'(1)) begin
          last_d = ts_in;
        end
      end
    end

    // load the serial unit for a timed edge
    if (start_edge_ser) begin
      ts_sr_d  = ts_in;
      rising_d = pin;
      cyc_d    = '0;
      brw_d    = 1'b0;
      cry_d    = 1'b0;
      gt_d     = 1'b0;
    end

    // accepted poll
    if (in_acc && is_poll) begin
      resp_d.code = '0;
      resp_d.vel  = '0;
      if (err_q) begin
        edge_count_d  = '0;
        bit_index_d   = '0;
        err_d         = 1'b0;
        resp_d.status = ST_MISMATCH;
      end else if (edge_full) begin
        edge_count_d  = '0;
        bit_index_d   = '0;
        resp_d.status = ST_SUCCESS;
        resp_d.code   = CODE_W'(code_q);
        if (period_zero) begin
          resp_d.vel = '1;
        end
      end else if (edge_count_q == '0) begin
        resp_d.status = ST_NONE;
      end else begin
        ts_sr_d  = ts_in;
        tmo_sr_d = reading_timeout_q;
        cyc_d    = '0;
        brw_d    = 1'b0;
        gt_d     = 1'b0;
      end
    end

    // one bit of the serial subtract per cycle
    if (ser_en) begin
      brw_d   = (~ser_a & ser_b) | (~(ser_a ^ ser_b) & brw_q);
      ts_sr_d = {1'b0, ts_sr_q[TS_W-1:1]};
      cyc_d   = cyc_q + SER_CNT_W'(1);
      gt_d    = gt_nxt;
      if (state_q == S_EDGE) begin
        last_d = {ser_a, last_q[TS_W-1:1]};
        if (rising_q) begin
          // black duration: compare with white and sum the bit period
          white_d  = {ser_w, white_q[TS_W-1:1]};
          period_d = {ser_sum, period_q[TS_W-1:1]};
          cry_d    = (ser_w & ser_diff) | ((ser_w ^ ser_diff) & cry_q);
        end else begin
          white_d = {ser_diff, white_q[TS_W-1:1]};
        end
      end else begin
        last_d   = {ser_b, last_q[TS_W-1:1]};
        tmo_sr_d = {1'b0, tmo_sr_q[CFG_W-1:1]};
      end
    end

    // end of a serial pass
    if (ser_last) begin
      if (state_q == S_EDGE) begin
        if (rising_q) begin
          for (int i = 0; i < CODE_BITS; i++) begin
            if (IDX_W'(CODE_BITS - 1 - i) == bit_index_q) begin
              code_d[i] = gt_nxt;
            end
          end
          bit_index_d = bit_index_q + IDX_W'(1);
        end
      end else if (gt_nxt) begin
        edge_count_d  = '0;
        bit_index_d   = '0;
        resp_d.status = ST_TIMEOUT;
      end else begin
        resp_d.status = ST_PROGRESS;
      end
    end

    // velocity from the divider
    if (div_done) begin
      resp_d.vel = div_quo;
    end
  end

  // ---------------------------------------------------------------- divider
  etbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_div),
    .dividend_i (TS_W'(bit_length_q) * VEL_SCALE),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------- config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_length_q      <= '0;
      reading_timeout_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIT_LENGTH:      bit_length_q      <= cfg_data_i;
        CFG_READING_TIMEOUT: reading_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      edge_count_q <= '0;
      bit_index_q  <= '0;
      last_q       <= '0;
      err_q        <= 1'b0;
      cyc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_count_q <= edge_count_d;
      bit_index_q  <= bit_index_d;
      last_q       <= last_d;
      err_q        <= err_d;
      cyc_q        <= cyc_d;
      if (resp_wr) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    white_q  <= white_d;
    period_q <= period_d;
    code_q   <= code_d;
    ts_sr_q  <= ts_sr_d;
    tmo_sr_q <= tmo_sr_d;
    brw_q    <= brw_d;
    cry_q    <= cry_d;
    gt_q     <= gt_d;
    rising_q <= rising_d;
    resp_q   <= resp_d;
    if (resp_wr) begin
      out_q <= resp_q;
    end
  end

  // ---------------------------------------------------------------- ports
  assign s_axis_tready_o = ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.vel, out_q.code};
  assign m_axis_tuser_o  = out_q.status;

endmodule
